FILE: rtl/core/source_sequence_replay_filter_unit_assert.svh
// Assertion macros shared by the replay filter RTL.
`ifndef SOURCE_SEQUENCE_REPLAY_FILTER_UNIT_ASSERT_SVH
`define SOURCE_SEQUENCE_REPLAY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSRF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ssrf_pkg.sv
// Shared types, constants and helpers of the replay filter.
package ssrf_pkg;

    // Table geometry.
    localparam int LANES   = 8;
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W   = $clog2(LANES + 1);
    localparam logic [LANE_W-1:0] LAST_IDX = LANE_W'(LANES - 1);

    // Request codes.
    localparam logic [1:0] MODE_OBSERVE = 2'd0;
    localparam logic [1:0] MODE_RETIRE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // Verdict codes.
    localparam logic [1:0] VERDICT_READY     = 2'd0;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
    localparam logic [1:0] VERDICT_STALE     = 2'd2;
    localparam logic [1:0] VERDICT_CAPACITY  = 2'd3;

    // One lane of the table, also the form in which a request is held.
    typedef struct packed {
        logic [63:0] device;
        logic [2:0]  kind;
        logic [31:0] generation;
        logic [63:0] seq_num;
        logic [63:0] stamp;
    } t_entry;

    // Compare flags of one lane against the held request.
    typedef struct packed {
        logic exact;
        logic exact_retired;
        logic seq_equal;
        logic went_back;
        logic sib_older;
        logic sib_newer;
        logic lane_free;
    } t_match;

    // Table changes to apply when the result is committed.
    typedef struct packed {
        logic wr;
        logic grow;
        logic retire;
        logic clear;
    } t_act;

    // Occupied lane count clipped to the four-bit result field.
    function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] count);
        logic [CNT_W+3:0] wide;
        wide = {4'b0000, count};
        if (wide > (CNT_W + 4)'(15)) begin
            return 4'hF;
        end else begin
            return wide[3:0];
        end
    endfunction

endpackage

FILE: rtl/core/ssrf_lane_ram.sv
// Lane table memory: one write port and one registered read port.
module ssrf_lane_ram (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ssrf_pkg::LANE_W-1:0] i_wr_addr,
    input  ssrf_pkg::t_entry            i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ssrf_pkg::LANE_W-1:0] i_rd_addr,
    output ssrf_pkg::t_entry            o_rd_data
);

    ssrf_pkg::t_entry r_mem [ssrf_pkg::LANES];
    ssrf_pkg::t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/ssrf_lane_match.sv
// Compares one lane read from the table against the held request.
module ssrf_lane_match (
    input  ssrf_pkg::t_entry i_lane,
    input  logic             i_used,
    input  logic             i_retired,
    input  ssrf_pkg::t_entry i_req,
    output ssrf_pkg::t_match o_match
);

    logic same_src;
    logic gen_equal;
    logic sibling;

    // Key comparison: device and kind first, then generation.
    assign same_src  = i_used && (i_lane.device == i_req.device) &&
                       (i_lane.kind == i_req.kind);
    assign gen_equal = (i_lane.generation == i_req.generation);
    assign sibling   = same_src && i_retired && !gen_equal;

    // Flags for the scan decision.
    always_comb begin
        o_match.exact         = same_src && gen_equal;
        o_match.exact_retired = i_retired;
        o_match.seq_equal     = (i_req.seq_num == i_lane.seq_num);
        o_match.went_back     = (i_req.seq_num < i_lane.seq_num) ||
                                (i_req.stamp < i_lane.stamp);
        o_match.sib_older     = sibling && (i_req.generation < i_lane.generation);
        o_match.sib_newer     = sibling && (i_req.generation > i_lane.generation);
        o_match.lane_free     = !i_used;
    end

endmodule

FILE: rtl/core/source_sequence_replay_filter_unit.sv
// Replay filter top level: request sequencer, lane flags, and result register.
// An observe or retire request scans the lane table in index order, one memory
// read per lane with the compare in the cycle after the read, and stops early on
// an exact key match or, for observe, an older-generation hit. A request passes
// from idle through the scan state to a done state, where it commits once the
// result register is free; the single read port of the lane memory paces the
// scan. Clear and the unused request code skip the scan. One request is in
// work at a time, and the result register lets a new request be taken while
// the previous result still waits to be transferred out. Used and retired
// flags sit in flip-flops, so reset and clear take effect at once.

`include "source_sequence_replay_filter_unit_assert.svh"

module source_sequence_replay_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_device_key,
    input  logic [2:0]  i_source_kind,
    input  logic [31:0] i_generation,
    input  logic [63:0] i_sequence_req,
    input  logic [63:0] i_stamp_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    output logic [3:0]  o_lanes_in_use
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                        r_state,     n_state;
    ssrf_pkg::t_entry              r_req,       n_req;
    logic [1:0]                    r_mode,      n_mode;
    logic [ssrf_pkg::LANE_W-1:0]   r_rd_idx,    n_rd_idx;
    logic                          r_cmp_vld,   n_cmp_vld;
    logic [ssrf_pkg::LANE_W-1:0]   r_cmp_idx,   n_cmp_idx;
    logic                          r_reuse_vld, n_reuse_vld;
    logic [ssrf_pkg::LANE_W-1:0]   r_reuse_idx, n_reuse_idx;
    logic                          r_free_vld,  n_free_vld;
    logic [ssrf_pkg::LANE_W-1:0]   r_free_idx,  n_free_idx;
    ssrf_pkg::t_act                r_act,       n_act;
    logic [ssrf_pkg::LANE_W-1:0]   r_act_idx,   n_act_idx;
    logic [1:0]                    r_verdict,   n_verdict;
    logic [ssrf_pkg::LANES-1:0]    r_used;
    logic [ssrf_pkg::LANES-1:0]    r_retired;
    logic [ssrf_pkg::CNT_W-1:0]    r_count,     n_count;
    logic                          r_out_valid, n_out_valid;
    logic [1:0]                    r_out_verdict, n_out_verdict;
    logic [3:0]                    r_out_count, n_out_count;

    logic                          commit;
    logic                          ram_rd_en;
    ssrf_pkg::t_entry              ram_rd_data;
    ssrf_pkg::t_match              lane_m;
    logic                          cur_reuse_vld;
    logic [ssrf_pkg::LANE_W-1:0]   cur_reuse_idx;
    logic                          cur_free_vld;
    logic [ssrf_pkg::LANE_W-1:0]   cur_free_idx;

    // Lane table memory.
    ssrf_lane_ram u_lane_ram (
        .i_clk     (i_clk),
        .i_wr_en   (commit && r_act.wr),
        .i_wr_addr (r_act_idx),
        .i_wr_data (r_req),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (ram_rd_data)
    );

    // Compare of the lane that the memory returned this cycle.
    ssrf_lane_match u_lane_match (
        .i_lane    (ram_rd_data),
        .i_used    (r_used[r_cmp_idx]),
        .i_retired (r_retired[r_cmp_idx]),
        .i_req     (r_req),
        .o_match   (lane_m)
    );

    // Handshake outputs.
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_out_verdict;
    assign o_lanes_in_use = r_out_count;

    // Sequencer: accept, scan, commit.
    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_mode        = r_mode;
        n_rd_idx      = r_rd_idx;
        n_cmp_vld     = r_cmp_vld;
        n_cmp_idx     = r_cmp_idx;
        n_reuse_vld   = r_reuse_vld;
        n_reuse_idx   = r_reuse_idx;
        n_free_vld    = r_free_vld;
        n_free_idx    = r_free_idx;
        n_act         = r_act;
        n_act_idx     = r_act_idx;
        n_verdict     = r_verdict;
        ram_rd_en     = 1'b0;
        commit        = 1'b0;
        cur_reuse_vld = r_reuse_vld;
        cur_reuse_idx = r_reuse_idx;
        cur_free_vld  = r_free_vld;
        cur_free_idx  = r_free_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req.device     = i_device_key;
                    n_req.kind       = i_source_kind;
                    n_req.generation = i_generation;
                    n_req.seq_num    = i_sequence_req;
                    n_req.stamp      = i_stamp_us;
                    n_mode           = i_mode;
                    n_rd_idx         = '0;
                    n_cmp_vld        = 1'b0;
                    n_reuse_vld      = 1'b0;
                    n_free_vld       = 1'b0;
                    n_act            = '0;
                    n_verdict        = ssrf_pkg::VERDICT_READY;
                    if (i_mode == ssrf_pkg::MODE_OBSERVE ||
                        i_mode == ssrf_pkg::MODE_RETIRE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_act.clear = (i_mode == ssrf_pkg::MODE_CLEAR);
                        n_state     = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next read; the index holds at the last lane.
                ram_rd_en = 1'b1;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_rd_idx;
                if (r_rd_idx != ssrf_pkg::LAST_IDX) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end

                if (r_cmp_vld) begin
                    if (r_mode == ssrf_pkg::MODE_RETIRE) begin
                        // Retire the first exact match, if any.
                        if (lane_m.exact) begin
                            n_act.retire = 1'b1;
                            n_act_idx    = r_cmp_idx;
                            n_state      = S_DONE;
                        end else if (r_cmp_idx == ssrf_pkg::LAST_IDX) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        // Remember reuse and free candidates seen so far.
                        if (lane_m.sib_newer) begin
                            cur_reuse_vld = 1'b1;
                            cur_reuse_idx = r_cmp_idx;
                        end
                        if (lane_m.lane_free && !r_free_vld) begin
                            cur_free_vld = 1'b1;
                            cur_free_idx = r_cmp_idx;
                        end
                        n_reuse_vld = cur_reuse_vld;
                        n_reuse_idx = cur_reuse_idx;
                        n_free_vld  = cur_free_vld;
                        n_free_idx  = cur_free_idx;

                        priority if (lane_m.exact) begin
                            n_state = S_DONE;
                            priority if (lane_m.exact_retired) begin
                                n_verdict = ssrf_pkg::VERDICT_STALE;
                            end else if (lane_m.seq_equal) begin
                                n_verdict = ssrf_pkg::VERDICT_DUPLICATE;
                            end else if (lane_m.went_back) begin
                                n_verdict = ssrf_pkg::VERDICT_STALE;
                            end else begin
                                n_verdict = ssrf_pkg::VERDICT_READY;
                                n_act.wr  = 1'b1;
                                n_act_idx = r_cmp_idx;
                            end
                        end else if (lane_m.sib_older) begin
                            n_state   = S_DONE;
                            n_verdict = ssrf_pkg::VERDICT_STALE;
                        end else if (r_cmp_idx == ssrf_pkg::LAST_IDX) begin
                            // End of scan: reuse beats a free lane.
                            n_state = S_DONE;
                            priority if (cur_reuse_vld) begin
                                n_verdict = ssrf_pkg::VERDICT_READY;
                                n_act.wr  = 1'b1;
                                n_act_idx = cur_reuse_idx;
                            end else if (cur_free_vld) begin
                                n_verdict  = ssrf_pkg::VERDICT_READY;
                                n_act.wr   = 1'b1;
                                n_act.grow = 1'b1;
                                n_act_idx  = cur_free_idx;
                            end else begin
                                n_verdict = ssrf_pkg::VERDICT_CAPACITY;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end

                if (n_state == S_DONE) begin
                    n_cmp_vld = 1'b0;
                end
            end

            S_DONE: begin
                // Commit once the result register is free.
                if (!r_out_valid || !i_out_stall) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Lane count after the commit and the result register.
    always_comb begin
        n_count = r_count;
        if (commit) begin
            if (r_act.clear) begin
                n_count = '0;
            end else if (r_act.grow) begin
                n_count = r_count + ssrf_pkg::CNT_W'(1);
            end
        end

        n_out_valid   = r_out_valid && i_out_stall;
        n_out_verdict = r_out_verdict;
        n_out_count   = r_out_count;
        if (commit) begin
            n_out_valid   = 1'b1;
            n_out_verdict = r_verdict;
            n_out_count   = ssrf_pkg::sat_count(n_count);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_used      <= '0;
            r_retired   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (commit) begin
                if (r_act.clear) begin
                    r_used    <= '0;
                    r_retired <= '0;
                end
                if (r_act.wr) begin
                    r_used[r_act_idx]    <= 1'b1;
                    r_retired[r_act_idx] <= 1'b0;
                end
                if (r_act.retire) begin
                    r_retired[r_act_idx] <= 1'b1;
                end
            end
        end
    end

    // Request, scan bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_mode        <= n_mode;
        r_rd_idx      <= n_rd_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_reuse_vld   <= n_reuse_vld;
        r_reuse_idx   <= n_reuse_idx;
        r_free_vld    <= n_free_vld;
        r_free_idx    <= n_free_idx;
        r_act         <= n_act;
        r_act_idx     <= n_act_idx;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_out_count   <= n_out_count;
    end

    // Checks on the sequencer and the lane bookkeeping.
    `SSRF_ASSERT_IMPLIES(a_cmp_in_scan, r_cmp_vld, r_state == S_SCAN, "compare active outside scan")
    `SSRF_ASSERT_IMPLIES(a_grow_free, commit && r_act.grow, !r_used[r_act_idx] && r_act.wr, "allocation into an occupied lane")
    `SSRF_ASSERT_IMPLIES(a_count_match, 1'b1, r_count == $countones(r_used), "lane count out of step with used flags")
    `SSRF_ASSERT_NEXT(a_clear_empties, commit && r_act.clear, r_used == '0 && r_retired == '0, "clear left lanes in use")

endmodule

FILE: tb/source_sequence_replay_filter_unit_tb.sv
// Self-checking testbench of the replay filter: directed script, then random event streams.
module source_sequence_replay_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The request code that the block leaves unused.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [63:0] ALL64 = '1;
    localparam logic [31:0] ALL32 = '1;

    localparam int SCRIPT_ROWS = 28;
    localparam int POOL        = 9;
    localparam int PHASE_ITEMS = 584;
    localparam int TAIL_CYCLES = 4 * (ssrf_pkg::LANES + 3);
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] device;
        logic [2:0]  kind;
        logic [31:0] gen;
        logic [63:0] seq;
        logic [63:0] stamp;
    } t_req;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] lanes;
    } t_result;

    typedef struct packed {
        t_req    req;
        logic    has_want;
        t_result want;
    } t_row;

    // Clock, reset and the driven side of both channels.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_mode = '0;
    logic [63:0] in_device = '0;
    logic [2:0]  in_kind = '0;
    logic [31:0] in_gen = '0;
    logic [63:0] in_seq = '0;
    logic [63:0] in_stamp = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  out_verdict;
    logic [3:0]  out_lanes;

    // Shadow copy of the lane table.
    logic        tbl_used [ssrf_pkg::LANES] = '{default: 1'b0};
    logic        tbl_retired [ssrf_pkg::LANES] = '{default: 1'b0};
    logic [63:0] tbl_device [ssrf_pkg::LANES] = '{default: '0};
    logic [2:0]  tbl_kind [ssrf_pkg::LANES] = '{default: '0};
    logic [31:0] tbl_gen [ssrf_pkg::LANES] = '{default: '0};
    logic [63:0] tbl_seq [ssrf_pkg::LANES] = '{default: '0};
    logic [63:0] tbl_stamp [ssrf_pkg::LANES] = '{default: '0};

    t_result pending_verdicts [$];
    t_row    script [SCRIPT_ROWS];
    t_req    pool [POOL];

    int send_idle_pct = 17;
    int recv_stall_pct = 87;
    int error_count = 0;
    int cycle_count = 0;

    source_sequence_replay_filter_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (in_mode),
        .i_device_key   (in_device),
        .i_source_kind  (in_kind),
        .i_generation   (in_gen),
        .i_sequence_req (in_seq),
        .i_stamp_us     (in_stamp),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_verdict      (out_verdict),
        .o_lanes_in_use (out_lanes)
    );

    initial forever #4 clk = ~clk;

    // Works out the verdict of one request and applies it to the shadow table.
    function automatic t_result judge_request(input t_req rq);
        t_result res;
        int      free_lane;
        int      reuse_lane;
        int      target;
        int      used_count;
        logic    same_src;
        logic    done;
        res.verdict = ssrf_pkg::VERDICT_READY;
        free_lane = -1;
        reuse_lane = -1;
        done = 1'b0;
        unique case (rq.mode)
            ssrf_pkg::MODE_OBSERVE: begin
                for (int i = 0; i < ssrf_pkg::LANES && !done; i++) begin
                    same_src = tbl_used[i] && tbl_device[i] == rq.device &&
                               tbl_kind[i] == rq.kind;
                    if (same_src && tbl_gen[i] == rq.gen) begin
                        done = 1'b1;
                        if (tbl_retired[i]) begin
                            res.verdict = ssrf_pkg::VERDICT_STALE;
                        end else if (rq.seq == tbl_seq[i]) begin
                            res.verdict = ssrf_pkg::VERDICT_DUPLICATE;
                        end else if (rq.seq < tbl_seq[i] || rq.stamp < tbl_stamp[i]) begin
                            res.verdict = ssrf_pkg::VERDICT_STALE;
                        end else begin
                            tbl_seq[i] = rq.seq;
                            tbl_stamp[i] = rq.stamp;
                        end
                    end else begin
                        // A retired older attachment may be taken over; a newer one wins.
                        if (same_src && tbl_retired[i]) begin
                            if (rq.gen < tbl_gen[i]) begin
                                res.verdict = ssrf_pkg::VERDICT_STALE;
                                done = 1'b1;
                            end else begin
                                reuse_lane = i;
                            end
                        end
                        if (!tbl_used[i] && free_lane < 0) begin
                            free_lane = i;
                        end
                    end
                end
                if (!done) begin
                    target = (reuse_lane >= 0) ? reuse_lane : free_lane;
                    if (target < 0) begin
                        res.verdict = ssrf_pkg::VERDICT_CAPACITY;
                    end else begin
                        tbl_used[target] = 1'b1;
                        tbl_retired[target] = 1'b0;
                        tbl_device[target] = rq.device;
                        tbl_kind[target] = rq.kind;
                        tbl_gen[target] = rq.gen;
                        tbl_seq[target] = rq.seq;
                        tbl_stamp[target] = rq.stamp;
                    end
                end
            end
            ssrf_pkg::MODE_RETIRE: begin
                for (int i = 0; i < ssrf_pkg::LANES && !done; i++) begin
                    if (tbl_used[i] && tbl_device[i] == rq.device && tbl_kind[i] == rq.kind &&
                        tbl_gen[i] == rq.gen) begin
                        tbl_retired[i] = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            ssrf_pkg::MODE_CLEAR: begin
                for (int i = 0; i < ssrf_pkg::LANES; i++) begin
                    tbl_used[i] = 1'b0;
                    tbl_retired[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        used_count = 0;
        for (int i = 0; i < ssrf_pkg::LANES; i++) begin
            used_count += tbl_used[i] ? 1 : 0;
        end
        res.lanes = (used_count > 15) ? 4'hF : 4'(used_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Presents one request, holds it until the transfer, then records what must come back.
    task automatic push_request(input t_req rq, input logic has_want, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode <= rq.mode;
        in_device <= rq.device;
        in_kind <= rq.kind;
        in_gen <= rq.gen;
        in_seq <= rq.seq;
        in_stamp <= rq.stamp;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predicted = judge_request(rq);
        pending_verdicts.push_back(has_want ? want : predicted);
    endtask

    // Holds the sender back until every outstanding result has been transferred.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Random event streams: mostly in-order traffic from a small pool of sources.
    task automatic run_random_phase(input int count, input int send_pct, input int stall_pct);
        t_req rq;
        int   p;
        int   r;
        int   q;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                drain_results();
            end
            p = $urandom_range(POOL - 1);
            r = $urandom_range(99);
            rq = pool[p];
            if (r < 60) begin
                q = $urandom_range(9);
                if (q == 1) begin
                    rq.seq = pool[p].seq - 64'($urandom_range(20, 1));
                end else if (q == 2) begin
                    rq.seq = pool[p].seq + 64'd1;
                    rq.stamp = pool[p].stamp - 64'($urandom_range(20, 1));
                end else if (q != 0) begin
                    pool[p].seq += 64'($urandom_range(1000, 1));
                    pool[p].stamp += 64'($urandom_range(5000, 0));
                    rq = pool[p];
                end
            end else if (r < 70) begin
                // Detach the current generation; the source comes back newer.
                rq.mode = ssrf_pkg::MODE_RETIRE;
                pool[p].gen += 32'($urandom_range(3, 1));
                pool[p].seq = 64'($urandom_range(100, 0));
            end else if (r < 76) begin
                rq.gen = pool[p].gen - 32'($urandom_range(4, 1));
            end else if (r < 80) begin
                // A fresh source, sometimes on a device that another one already uses.
                if ($urandom_range(2) == 0) begin
                    pool[p].device = pool[$urandom_range(POOL - 1)].device;
                end else begin
                    pool[p].device = {$urandom, $urandom};
                end
                pool[p].kind = 3'($urandom_range(7));
                pool[p].gen = $urandom;
                rq = pool[p];
            end else if (r < 83) begin
                rq.mode = ssrf_pkg::MODE_CLEAR;
            end else begin
                rq.device = {$urandom, $urandom};
                rq.kind = 3'($urandom_range(7));
                rq.gen = $urandom;
                rq.seq = {$urandom, $urandom};
                rq.stamp = {$urandom, $urandom};
                rq.mode = (r < 85) ? MODE_UNUSED : 2'($urandom_range(3));
            end
            push_request(rq, 1'b0, '0);
        end
    endtask

    // Result side: random stall, and each transfer checked against the oldest expectation.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing outstanding", 64'(out_verdict), 64'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (out_verdict != want.verdict) begin
                    report_mismatch("verdict", 64'(out_verdict), 64'(want.verdict));
                end
                if (out_lanes != want.lanes) begin
                    report_mismatch("lanes_in_use", 64'(out_lanes), 64'(want.lanes));
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        script = '{
            // Allocation, duplicate, sequence going back and stamp going back.
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd1}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_DUPLICATE, 4'd1}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd5, 64'd5}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd1}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd4, 64'd9}, 1'b1,
              '{ssrf_pkg::VERDICT_STALE, 4'd1}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd6, 64'd4}, 1'b1,
              '{ssrf_pkg::VERDICT_STALE, 4'd1}},
            '{'{ssrf_pkg::MODE_OBSERVE, ALL64, 3'd7, ALL32, ALL64, ALL64}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd2}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd1, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            // Retired exact match, reuse by a newer generation, older generation refused.
            '{'{ssrf_pkg::MODE_RETIRE, 64'd0, 3'd0, 32'd0, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd0, 64'd10, 64'd10}, 1'b1,
              '{ssrf_pkg::VERDICT_STALE, 4'd3}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd0, 3'd0, 32'd1, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            '{'{ssrf_pkg::MODE_RETIRE, ALL64, 3'd7, ALL32, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            '{'{ssrf_pkg::MODE_OBSERVE, ALL64, 3'd7, 32'd5, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_STALE, 4'd3}},
            // Unused request code and a retire that finds nothing.
            '{'{MODE_UNUSED, ALL64, 3'd7, ALL32, ALL64, ALL64}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            '{'{ssrf_pkg::MODE_RETIRE, 64'd42, 3'd3, 32'd9, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd3}},
            // Fill the table, then one more source finds no room.
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd1, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd4}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd2, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd5}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd3, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd6}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd4, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd7}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd5, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd8}},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd6, 3'd0, 32'd0, 64'd1, 64'd1}, 1'b1,
              '{ssrf_pkg::VERDICT_CAPACITY, 4'd8}},
            '{'{ssrf_pkg::MODE_CLEAR, 64'd0, 3'd0, 32'd0, 64'd0, 64'd0}, 1'b1,
              '{ssrf_pkg::VERDICT_READY, 4'd0}},
            // Two retired generations of one source: the later lane is the one reused.
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd9, 3'd2, 32'd2, 64'd100, 64'd100}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd9, 3'd2, 32'd1, 64'd50, 64'd50}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_RETIRE, 64'd9, 3'd2, 32'd2, 64'd0, 64'd0}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_RETIRE, 64'd9, 3'd2, 32'd1, 64'd0, 64'd0}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd9, 3'd2, 32'd3, 64'd1, 64'd200}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd9, 3'd2, 32'd2, 64'd7, 64'd300}, 1'b0, '0},
            '{'{ssrf_pkg::MODE_OBSERVE, 64'd9, 3'd2, 32'd3, 64'd2, 64'd201}, 1'b0, '0}
        };
        for (int i = 0; i < POOL; i++) begin
            pool[i].mode = ssrf_pkg::MODE_OBSERVE;
            pool[i].device = {$urandom, $urandom};
            pool[i].kind = 3'($urandom_range(7));
            pool[i].gen = $urandom;
            pool[i].seq = {$urandom, $urandom} >> 2;
            pool[i].stamp = {$urandom, $urandom} >> 2;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script, then a full drain before the random streams.
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            push_request(script[i].req, script[i].has_want, script[i].want);
        end
        drain_results();

        run_random_phase(PHASE_ITEMS, 17, 87);
        run_random_phase(PHASE_ITEMS, 87, 17);
        run_random_phase(PHASE_ITEMS, 0, 0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
